[rtl/scba_pkg.sv]
// size class block allocator: shared constants, types and reset helpers
// no dependencies
package scba_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int NUM_PAGES   = 128;
    localparam int NUM_CLASSES = 32;
    localparam int INFO_BYTES  = 256;

    localparam int ADDR_W = 19;
    localparam int REQ_W  = 16;
    localparam int CLS_W  = 5;
    localparam int CNT_W  = 16;
    localparam int SUM_W  = 32;
    localparam int STAT_W = 2;

    localparam int PAGE_BITS = $clog2(PAGE_BYTES);
    localparam int OFF_W     = $clog2(PAGE_BYTES / 8);
    localparam int OFF1_W    = OFF_W + 1;
    localparam int PG_W      = $clog2(NUM_PAGES);
    localparam int PGC_W     = PG_W + 1;
    localparam int LINK_AW   = PG_W + OFF_W;
    localparam int LINK_DW   = LINK_AW + 1;
    localparam int LINK_DEPTH = NUM_PAGES * (PAGE_BYTES / 8);
    localparam int BW_W      = $clog2(NUM_CLASSES + 1);
    localparam int TOT_W     = REQ_W + 1;
    localparam int HDR_BYTES = 8;
    localparam int USABLE_W  = (PAGE_BYTES > INFO_BYTES) ? (PAGE_BYTES - INFO_BYTES) / 8 : 0;
    localparam int TOTAL_MAX = NUM_CLASSES * 8;
    localparam int RESET_PAGES = (NUM_CLASSES < NUM_PAGES) ? NUM_CLASSES : NUM_PAGES;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_OOM       = 2'd2,
        ST_BAD       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_REJ_LARGE,
        OP_REJ_BAD
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CLS_W-1:0]   cls;
        logic [REQ_W-1:0]   req;
        logic [ADDR_W-1:0]  addr;
        logic [PG_W-1:0]    pg;
        logic [OFF_W-1:0]   offw;
    } item_t;

    typedef struct packed {
        logic               head_vld;
        logic [LINK_AW-1:0] head;
        logic               next_vld;
        logic [PG_W-1:0]    next;
        logic [CLS_W-1:0]   cls;
        logic [OFF_W-1:0]   carve;
    } page_t;

    function automatic page_t page_reset(input logic [PG_W-1:0] p);
        page_t e;
        e.head_vld = ((int'(p) + 1) <= USABLE_W);
        e.head     = e.head_vld ? {p, {OFF_W{1'b0}}} : '0;
        e.next_vld = 1'b0;
        e.next     = '0;
        e.cls      = CLS_W'(p);
        e.carve    = '0;
        return e;
    endfunction

endpackage

[rtl/scba_fifo.sv]
// two-entry queue of classified commands between front and back
// depends on scba_pkg
module scba_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  scba_pkg::item_t din,
    output logic           full,
    input  logic           pop,
    output scba_pkg::item_t dout,
    output logic           empty
);

    scba_pkg::item_t mem_reg [2];
    logic            wp_reg;
    logic            rp_reg;
    logic [1:0]      cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign dout    = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/scba_front.sv]
// front: classifies a command into class, page and offset and screens static errors
// depends on scba_pkg
module scba_front (
    input  logic                          cmd,
    input  logic [scba_pkg::REQ_W-1:0]    req_bytes,
    input  logic [scba_pkg::ADDR_W-1:0]   free_addr,
    output scba_pkg::item_t               item
);

    logic [scba_pkg::TOT_W-1:0]  total;
    logic [scba_pkg::TOT_W-1:0]  rnd;
    logic [scba_pkg::ADDR_W-1:0] blk;

    always_comb
    begin
        total = scba_pkg::TOT_W'(req_bytes) + scba_pkg::TOT_W'(scba_pkg::HDR_BYTES);
        rnd   = (total + scba_pkg::TOT_W'(7)) >> 3;
        blk   = free_addr - scba_pkg::ADDR_W'(scba_pkg::HDR_BYTES);

        item.req  = req_bytes;
        item.addr = free_addr;
        item.cls  = scba_pkg::CLS_W'(rnd - scba_pkg::TOT_W'(1));
        item.pg   = blk[scba_pkg::PAGE_BITS +: scba_pkg::PG_W];
        item.offw = blk[3 +: scba_pkg::OFF_W];

        if (!cmd)
        begin
            if (total > scba_pkg::TOT_W'(scba_pkg::TOTAL_MAX))
            begin
                item.op = scba_pkg::OP_REJ_LARGE;
            end
            else
            begin
                item.op = scba_pkg::OP_ALLOC;
            end
        end
        else
        begin
            if (free_addr < scba_pkg::ADDR_W'(scba_pkg::HDR_BYTES) || blk[2:0] != 3'd0)
            begin
                item.op = scba_pkg::OP_REJ_BAD;
            end
            else
            begin
                item.op = scba_pkg::OP_FREE;
            end
        end
    end

endmodule

[rtl/scba_rem.sv]
// iterative remainder unit, one quotient bit per cycle
// depends on scba_pkg
module scba_rem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [scba_pkg::OFF_W-1:0]   dividend,
    input  logic [scba_pkg::BW_W-1:0]    divisor,
    output logic                         done,
    output logic [scba_pkg::BW_W-1:0]    rem
);

    localparam int CW = $clog2(scba_pkg::OFF_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CW-1:0]               cnt_reg;
    logic [scba_pkg::OFF_W-1:0]  sh_reg;
    logic [scba_pkg::BW_W-1:0]   div_reg;
    logic [scba_pkg::BW_W-1:0]   rem_reg;
    logic [scba_pkg::BW_W:0]     trial;
    logic [scba_pkg::BW_W-1:0]   rem_next;

    assign done = done_reg;
    assign rem  = rem_reg;

    always_comb
    begin
        trial = {rem_reg, sh_reg[scba_pkg::OFF_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = scba_pkg::BW_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = scba_pkg::BW_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            sh_reg   <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(scba_pkg::OFF_W);
                sh_reg   <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                sh_reg  <= sh_reg << 1;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/scba_back.sv]
// back: page chain walk, lazy page carving, free-list pop and push, counters
// depends on scba_pkg and scba_rem
module scba_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  scba_pkg::item_t               q_item,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [scba_pkg::ADDR_W-1:0]   addr,
    output logic [scba_pkg::STAT_W-1:0]   status,
    output logic [scba_pkg::CLS_W-1:0]    class_index,
    output logic [scba_pkg::CNT_W-1:0]    class_allocations,
    output logic [scba_pkg::SUM_W-1:0]    requested_total
);

    localparam int NP  = scba_pkg::NUM_PAGES;
    localparam int NC  = scba_pkg::NUM_CLASSES;
    localparam int PGW = scba_pkg::PG_W;
    localparam int OFW = scba_pkg::OFF_W;
    localparam int LAW = scba_pkg::LINK_AW;
    localparam int LDW = scba_pkg::LINK_DW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AWALK,
        S_ANEW,
        S_ALINK,
        S_APOP,
        S_APOPRD,
        S_AFIN,
        S_FRD,
        S_FDIV,
        S_FLRD
    } state_t;

    state_t                   state_reg;
    scba_pkg::item_t          item_reg;
    logic [PGW-1:0]           cur_pg_reg;
    scba_pkg::page_t          cur_reg;
    logic [PGW-1:0]           tail_pg_reg;
    scba_pkg::page_t          tail_reg;
    logic                     have_reg;
    logic [LAW-1:0]           w_reg;
    logic [scba_pkg::PGC_W-1:0] pages_used_reg;
    logic                     first_vld_reg [NC];
    logic [PGW-1:0]           first_pg_reg [NC];
    logic [scba_pkg::CNT_W-1:0] count_reg [NC];
    logic [scba_pkg::SUM_W-1:0] sum_reg;
    logic                     pvld_reg [NP];

    logic                     out_vld_reg;
    logic [scba_pkg::ADDR_W-1:0] addr_reg;
    scba_pkg::status_t        status_reg;
    logic [scba_pkg::CLS_W-1:0] cls_out_reg;
    logic [scba_pkg::CNT_W-1:0] cnt_out_reg;

    scba_pkg::page_t          page_mem [NP];
    scba_pkg::page_t          page_rd_reg;
    logic                     page_rdv_reg;
    logic [PGW-1:0]           page_raq_reg;
    logic [LDW-1:0]           link_mem [scba_pkg::LINK_DEPTH];
    logic [LDW-1:0]           link_rd_reg;

    logic [PGW-1:0]           page_ra;
    logic                     page_we;
    logic [PGW-1:0]           page_wa;
    scba_pkg::page_t          page_wd;
    logic [LAW-1:0]           link_ra;
    logic                     link_we;
    logic [LAW-1:0]           link_wa;
    logic [LDW-1:0]           link_wd;

    scba_pkg::page_t          page_eff;
    logic [scba_pkg::BW_W-1:0] bw_item;
    logic [scba_pkg::BW_W-1:0] bw_cur;
    logic [scba_pkg::BW_W-1:0] bw_div;
    logic                     carve_hit;
    logic [scba_pkg::OFF1_W-1:0] nxt_off;
    logic                     nxt_ok;
    logic [scba_pkg::CNT_W-1:0] cnt_item;
    logic [scba_pkg::CNT_W-1:0] cnt_dec;
    logic                     free_chk;
    logic                     free_ok;
    logic                     page_full;
    logic                     cls_fits;
    logic [LAW-1:0]           free_w;
    logic [LAW-1:0]           total_w;
    logic                     rem_start;
    logic                     rem_done;
    logic [scba_pkg::BW_W-1:0] rem_val;

    assign empty             = !out_vld_reg;
    assign addr              = addr_reg;
    assign status            = status_reg;
    assign class_index       = cls_out_reg;
    assign class_allocations = cnt_out_reg;
    assign requested_total   = sum_reg;

    scba_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (item_reg.offw),
        .divisor  (bw_div),
        .done     (rem_done),
        .rem      (rem_val)
    );

    always_comb
    begin
        page_eff  = page_rdv_reg ? page_rd_reg : scba_pkg::page_reset(page_raq_reg);
        bw_item   = scba_pkg::BW_W'(item_reg.cls) + scba_pkg::BW_W'(1);
        bw_cur    = scba_pkg::BW_W'(cur_reg.cls) + scba_pkg::BW_W'(1);
        bw_div    = scba_pkg::BW_W'(page_eff.cls) + scba_pkg::BW_W'(1);
        carve_hit = (cur_reg.head[OFW-1:0] == cur_reg.carve);
        nxt_off   = scba_pkg::OFF1_W'(cur_reg.carve) + scba_pkg::OFF1_W'(bw_item);
        nxt_ok    = (nxt_off + scba_pkg::OFF1_W'(bw_item))
                    <= scba_pkg::OFF1_W'(scba_pkg::USABLE_W);
        cnt_item  = count_reg[item_reg.cls];
        cnt_dec   = (count_reg[cur_reg.cls] != '0) ? count_reg[cur_reg.cls] - 16'd1
                                                  : count_reg[cur_reg.cls];
        free_chk  = (rem_val == '0)
                    && ((scba_pkg::OFF1_W'(item_reg.offw) + scba_pkg::OFF1_W'(bw_cur))
                        <= scba_pkg::OFF1_W'(scba_pkg::USABLE_W))
                    && (item_reg.offw < cur_reg.carve);
        free_ok   = (link_rd_reg != '0) && !link_rd_reg[LAW];
        page_full = (pages_used_reg >= scba_pkg::PGC_W'(NP));
        cls_fits  = (int'(bw_item) <= scba_pkg::USABLE_W);
        free_w    = {item_reg.pg, item_reg.offw};
        total_w   = LAW'(item_reg.req) + LAW'(scba_pkg::HDR_BYTES);

        q_pop     = (state_reg == S_IDLE) && !q_empty && !out_vld_reg;
        rem_start = (state_reg == S_FRD);

        page_ra = cur_pg_reg;
        page_we = 1'b0;
        page_wa = cur_pg_reg;
        page_wd = cur_reg;
        link_ra = cur_reg.head;
        link_we = 1'b0;
        link_wa = w_reg;
        link_wd = {1'b0, total_w};

        case (state_reg)
            S_IDLE:
            begin
                page_ra = (q_item.op == scba_pkg::OP_ALLOC) ? first_pg_reg[q_item.cls]
                                                            : q_item.pg;
            end
            S_AWALK:
            begin
                page_ra = page_eff.next;
            end
            S_ALINK:
            begin
                page_we          = 1'b1;
                page_wa          = tail_pg_reg;
                page_wd          = tail_reg;
                page_wd.next_vld = 1'b1;
                page_wd.next     = cur_pg_reg;
            end
            S_AFIN:
            begin
                page_we = 1'b1;
                link_we = 1'b1;
            end
            S_FDIV:
            begin
                link_ra = free_w;
            end
            S_FLRD:
            begin
                page_we          = free_ok;
                page_wd.head_vld = 1'b1;
                page_wd.head     = free_w;
                link_we          = free_ok;
                link_wa          = free_w;
                link_wd          = {cur_reg.head_vld, cur_reg.head};
            end
            default:
            begin
            end
        endcase
    end

    // page table and link memory
    always_ff @(posedge clk)
    begin
        if (page_we)
        begin
            page_mem[page_wa] <= page_wd;
        end
        page_rd_reg <= page_mem[page_ra];
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd_reg <= link_mem[link_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NP; i++)
            begin
                pvld_reg[i] <= 1'b0;
            end
            page_rdv_reg <= 1'b0;
            page_raq_reg <= '0;
        end
        else
        begin
            if (page_we)
            begin
                pvld_reg[page_wa] <= 1'b1;
            end
            page_rdv_reg <= pvld_reg[page_ra];
            page_raq_reg <= page_ra;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            cur_pg_reg     <= '0;
            cur_reg        <= '0;
            tail_pg_reg    <= '0;
            tail_reg       <= '0;
            have_reg       <= 1'b0;
            w_reg          <= '0;
            pages_used_reg <= scba_pkg::PGC_W'(scba_pkg::RESET_PAGES);
            sum_reg        <= '0;
            for (int c = 0; c < NC; c++)
            begin
                first_vld_reg[c] <= (c < NP);
                first_pg_reg[c]  <= PGW'(c);
                count_reg[c]     <= '0;
            end
            out_vld_reg <= 1'b0;
            addr_reg    <= '0;
            status_reg  <= scba_pkg::ST_OK;
            cls_out_reg <= '0;
            cnt_out_reg <= '0;
        end
        else
        begin
            if (pop && out_vld_reg)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        item_reg <= q_item;
                        case (q_item.op)
                            scba_pkg::OP_ALLOC:
                            begin
                                cur_pg_reg <= first_pg_reg[q_item.cls];
                                have_reg   <= first_vld_reg[q_item.cls];
                                state_reg  <= first_vld_reg[q_item.cls] ? S_AWALK : S_ANEW;
                            end
                            scba_pkg::OP_FREE:
                            begin
                                cur_pg_reg <= q_item.pg;
                                if (scba_pkg::PGC_W'(q_item.pg) >= pages_used_reg)
                                begin
                                    out_vld_reg <= 1'b1;
                                    addr_reg    <= '0;
                                    status_reg  <= scba_pkg::ST_BAD;
                                    cls_out_reg <= '0;
                                    cnt_out_reg <= '0;
                                end
                                else
                                begin
                                    state_reg <= S_FRD;
                                end
                            end
                            scba_pkg::OP_REJ_LARGE:
                            begin
                                out_vld_reg <= 1'b1;
                                addr_reg    <= '0;
                                status_reg  <= scba_pkg::ST_TOO_LARGE;
                                cls_out_reg <= '0;
                                cnt_out_reg <= '0;
                            end
                            default:
                            begin
                                out_vld_reg <= 1'b1;
                                addr_reg    <= '0;
                                status_reg  <= scba_pkg::ST_BAD;
                                cls_out_reg <= '0;
                                cnt_out_reg <= '0;
                            end
                        endcase
                    end
                end
                S_AWALK:
                begin
                    cur_reg <= page_eff;
                    if (page_eff.head_vld)
                    begin
                        state_reg <= S_APOP;
                    end
                    else if (page_eff.next_vld)
                    begin
                        cur_pg_reg <= page_eff.next;
                    end
                    else
                    begin
                        tail_pg_reg <= cur_pg_reg;
                        tail_reg    <= page_eff;
                        state_reg   <= S_ANEW;
                    end
                end
                S_ANEW:
                begin
                    if (page_full || !cls_fits)
                    begin
                        out_vld_reg <= 1'b1;
                        addr_reg    <= '0;
                        status_reg  <= scba_pkg::ST_OOM;
                        cls_out_reg <= item_reg.cls;
                        cnt_out_reg <= cnt_item;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        pages_used_reg   <= pages_used_reg + scba_pkg::PGC_W'(1);
                        cur_pg_reg       <= PGW'(pages_used_reg);
                        cur_reg.head_vld <= 1'b1;
                        cur_reg.head     <= {PGW'(pages_used_reg), {OFW{1'b0}}};
                        cur_reg.next_vld <= 1'b0;
                        cur_reg.next     <= '0;
                        cur_reg.cls      <= item_reg.cls;
                        cur_reg.carve    <= '0;
                        if (have_reg)
                        begin
                            state_reg <= S_ALINK;
                        end
                        else
                        begin
                            first_vld_reg[item_reg.cls] <= 1'b1;
                            first_pg_reg[item_reg.cls]  <= PGW'(pages_used_reg);
                            state_reg                   <= S_APOP;
                        end
                    end
                end
                S_ALINK:
                begin
                    state_reg <= S_APOP;
                end
                S_APOP:
                begin
                    w_reg <= cur_reg.head;
                    if (carve_hit)
                    begin
                        cur_reg.head_vld <= nxt_ok;
                        cur_reg.head     <= nxt_ok ? {cur_pg_reg, OFW'(nxt_off)} : '0;
                        cur_reg.carve    <= OFW'(nxt_off);
                        state_reg        <= S_AFIN;
                    end
                    else
                    begin
                        state_reg <= S_APOPRD;
                    end
                end
                S_APOPRD:
                begin
                    cur_reg.head_vld <= link_rd_reg[LAW];
                    cur_reg.head     <= link_rd_reg[LAW-1:0];
                    state_reg        <= S_AFIN;
                end
                S_AFIN:
                begin
                    count_reg[item_reg.cls] <= cnt_item + 16'd1;
                    sum_reg     <= sum_reg + scba_pkg::SUM_W'(item_reg.req);
                    out_vld_reg <= 1'b1;
                    addr_reg    <= {w_reg, 3'b000} + scba_pkg::ADDR_W'(scba_pkg::HDR_BYTES);
                    status_reg  <= scba_pkg::ST_OK;
                    cls_out_reg <= item_reg.cls;
                    cnt_out_reg <= cnt_item + 16'd1;
                    state_reg   <= S_IDLE;
                end
                S_FRD:
                begin
                    cur_reg   <= page_eff;
                    state_reg <= S_FDIV;
                end
                S_FDIV:
                begin
                    if (rem_done)
                    begin
                        if (free_chk)
                        begin
                            state_reg <= S_FLRD;
                        end
                        else
                        begin
                            out_vld_reg <= 1'b1;
                            addr_reg    <= '0;
                            status_reg  <= scba_pkg::ST_BAD;
                            cls_out_reg <= '0;
                            cnt_out_reg <= '0;
                            state_reg   <= S_IDLE;
                        end
                    end
                end
                S_FLRD:
                begin
                    out_vld_reg <= 1'b1;
                    if (free_ok)
                    begin
                        count_reg[cur_reg.cls] <= cnt_dec;
                        sum_reg     <= sum_reg - scba_pkg::SUM_W'(link_rd_reg[LAW-1:0])
                                       + scba_pkg::SUM_W'(scba_pkg::HDR_BYTES);
                        addr_reg    <= item_reg.addr;
                        status_reg  <= scba_pkg::ST_OK;
                        cls_out_reg <= cur_reg.cls;
                        cnt_out_reg <= cnt_dec;
                    end
                    else
                    begin
                        addr_reg    <= '0;
                        status_reg  <= scba_pkg::ST_BAD;
                        cls_out_reg <= '0;
                        cnt_out_reg <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/size_class_block_allocator.sv]
// allocate: the back reads the first page of the class chain and walks further pages until one
// has a free block, links in a new page when none has, and reuses a freed block if there is one
// free: the block check is bit-serial; a bad page or alignment is answered from the idle state
// one command in the back at a time; a 2-entry queue takes new commands meanwhile
// reset is immediate: first pages are carved lazily, no memory sweep after reset
// top level: depends on scba_pkg, scba_front, scba_fifo, scba_back
module size_class_block_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          cmd,
    input  logic [scba_pkg::REQ_W-1:0]    req_bytes,
    input  logic [scba_pkg::ADDR_W-1:0]   free_addr,
    output logic                          empty,
    input  logic                          pop,
    output logic [scba_pkg::ADDR_W-1:0]   addr,
    output logic [scba_pkg::STAT_W-1:0]   status,
    output logic [scba_pkg::CLS_W-1:0]    class_index,
    output logic [scba_pkg::CNT_W-1:0]    class_allocations,
    output logic [scba_pkg::SUM_W-1:0]    requested_total
);

    scba_pkg::item_t fr_item;
    scba_pkg::item_t q_item;
    logic            q_empty;
    logic            q_pop;

    scba_front u_front (
        .cmd       (cmd),
        .req_bytes (req_bytes),
        .free_addr (free_addr),
        .item      (fr_item)
    );

    scba_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (fr_item),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_item),
        .empty (q_empty)
    );

    scba_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .empty             (empty),
        .pop               (pop),
        .addr              (addr),
        .status            (status),
        .class_index       (class_index),
        .class_allocations (class_allocations),
        .requested_total   (requested_total)
    );

endmodule
